FILE: sv/fpgs_pkg.sv
// Package for the fictitious play matrix game solver.
// Holds sizes, register indexes and the request structs; no dependencies.
package fpgs_pkg;
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int FRAC_BITS   = 14;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int SUM_W       = 28;
    localparam int CNT_W       = 12;
    localparam int CFG_W       = 12;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_ROUNDS = 2'd2;

    localparam logic [1:0] KIND_ROW   = 2'd0;
    localparam logic [1:0] KIND_COL   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    typedef struct packed {
        logic signed [15:0] payoff_entry;
        logic               last_entry;
    } t_in;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [3:0]         result_index;
        logic [11:0]        play_count;
        logic signed [15:0] game_value;
        logic               last_result;
    } t_out;
endpackage

FILE: sv/fictitious_play_game_solver.sv
// Top level of the fictitious play matrix game solver.
// Uses fpgs_pkg for types and constants.
//
//  channel  | handshake           | payload
//  in       | i_valid / o_stall   | i_data (t_in)
//  out      | o_valid / i_stall   | o_data (t_out)
//  config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Entries load one per cycle while o_stall is low. After the last entry a solve
// clears the sums, then runs the configured rounds and a final search for the
// least column sum: one shared adder and the comparators walk the sums
// one element a cycle and the payoff memory gives one read per cycle.
// The value division is restoring, one quotient bit a cycle.
// Results then leave one per cycle while i_stall is low.
// Reset is synchronous, active low; the payoff memory is not cleared.
module fictitious_play_game_solver (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  fpgs_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output fpgs_pkg::t_out   o_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [11:0]      i_cfg_data
);
    import fpgs_pkg::*;

    localparam int DIV_W = SUM_W + 2;

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_CADD, S_CMIN, S_RADD, S_RMAX,
        S_FIN, S_DIV, S_EMIT
    } t_state;

    t_state r_state;
    logic [4:0]  r_rows_cfg, r_cols_cfg;
    logic [11:0] r_rounds_cfg;
    logic [ADDR_W-1:0] r_load_pos;
    logic signed [15:0] r_mem [STORE_DEPTH];
    logic signed [15:0] r_rd;
    logic signed [SUM_W-1:0] r_row_sums [MAX_ROWS];
    logic signed [SUM_W-1:0] r_col_sums [MAX_COLS];
    logic [CNT_W-1:0] r_row_plays [MAX_ROWS];
    logic [CNT_W-1:0] r_col_plays [MAX_COLS];
    logic [4:0]  r_nr, r_nc;
    logic [11:0] r_nrounds, r_round;
    logic [4:0]  r_idx;
    logic        r_rd_ok;   // the read data in r_rd belongs to r_idx-1
    logic [ROW_W-1:0] r_pick;
    logic [COL_W-1:0] r_col;
    logic signed [SUM_W-1:0] r_best;
    logic [DIV_W-1:0] r_num, r_rem;
    logic [12:0] r_den;
    logic        r_neg;
    logic [4:0]  r_bit;
    logic signed [15:0] r_value;
    logic [5:0]  r_emit;
    logic        r_ovalid;
    t_out        r_odata;
    t_out        n_odata;

    logic [4:0] w_nr, w_nc;
    assign w_nr = (r_rows_cfg == 5'd0) ? 5'd1 :
                  (r_rows_cfg > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : r_rows_cfg;
    assign w_nc = (r_cols_cfg == 5'd0) ? 5'd1 :
                  (r_cols_cfg > 5'(MAX_COLS)) ? 5'(MAX_COLS) : r_cols_cfg;

    // One memory read address, chosen by the phase.
    logic [4:0] w_rd_idx;
    logic [ADDR_W+1:0] w_addr;
    always_comb begin
        w_rd_idx = r_idx;
        if (r_state == S_CADD)
            w_addr = (ADDR_W+2)'(r_pick) * (ADDR_W+2)'(r_nc) + (ADDR_W+2)'(w_rd_idx);
        else
            w_addr = (ADDR_W+2)'(w_rd_idx) * (ADDR_W+2)'(r_nc) + (ADDR_W+2)'(r_col);
    end

    logic w_accept;
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_LOAD);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;

    always_ff @(posedge i_clk) begin
        if (w_accept)
            r_mem[r_load_pos] <= i_data.payoff_entry;
        r_rd <= r_mem[w_addr[ADDR_W-1:0]];
    end

    // Shared adder operand: the element being updated this cycle.
    logic [4:0] w_prev;
    logic signed [SUM_W-1:0] w_cur, w_sum, w_cand;
    logic [DIV_W-1:0] w_trial;
    assign w_prev = r_idx - 5'd1;
    assign w_cur  = (r_state == S_CADD) ? r_col_sums[w_prev[COL_W-1:0]]
                                        : r_row_sums[w_prev[ROW_W-1:0]];
    assign w_sum  = w_cur + SUM_W'(r_rd);
    assign w_cand = (r_state == S_CMIN || r_state == S_FIN) ?
                    r_col_sums[r_idx[COL_W-1:0]] : r_row_sums[r_idx[ROW_W-1:0]];
    assign w_trial = {r_rem[DIV_W-2:0], r_num[DIV_W-1]} - DIV_W'(r_den);

    // Next result: row counts, then column counts, then the game value.
    always_comb begin
        n_odata = '0;
        if (r_emit < 6'(r_nr)) begin
            n_odata.result_kind  = KIND_ROW;
            n_odata.result_index = 4'(r_emit);
            n_odata.play_count   = r_row_plays[r_emit[ROW_W-1:0]];
        end else if (r_emit < 6'(r_nr) + 6'(r_nc)) begin
            n_odata.result_kind  = KIND_COL;
            n_odata.result_index = 4'(r_emit - 6'(r_nr));
            n_odata.play_count   = r_col_plays[COL_W'(r_emit - 6'(r_nr))];
        end else begin
            n_odata.result_kind = KIND_VALUE;
            n_odata.game_value  = r_value;
            n_odata.last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_rows_cfg   <= 5'd16;
            r_cols_cfg   <= 5'd16;
            r_rounds_cfg <= 12'd200;
            r_load_pos   <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROWS:   r_rows_cfg   <= i_cfg_data[4:0];
                    REG_COLS:   r_cols_cfg   <= i_cfg_data[4:0];
                    REG_ROUNDS: r_rounds_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall && r_state != S_EMIT)
                r_ovalid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (i_data.last_entry) begin
                            r_load_pos <= '0;
                            r_nr       <= w_nr;
                            r_nc       <= w_nc;
                            r_nrounds  <= (r_rounds_cfg == 12'd0) ? 12'd1 : r_rounds_cfg;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_load_pos <= r_load_pos + 1'b1;
                        end
                    end
                end
                S_CLEAR: begin
                    for (int i = 0; i < MAX_ROWS; i++) begin
                        r_row_sums[i]  <= '0;
                        r_row_plays[i] <= '0;
                    end
                    for (int j = 0; j < MAX_COLS; j++) begin
                        r_col_sums[j]  <= '0;
                        r_col_plays[j] <= '0;
                    end
                    r_pick  <= '0;
                    r_round <= '0;
                    r_idx   <= '0;
                    r_rd_ok <= 1'b0;
                    r_state <= S_CADD;
                end
                S_CADD: begin
                    if (!r_rd_ok)
                        r_row_plays[r_pick] <= r_row_plays[r_pick] + 1'b1;
                    else
                        r_col_sums[w_prev[COL_W-1:0]] <= w_sum;
                    if (r_rd_ok && r_idx == r_nc) begin
                        r_idx <= 5'd1; r_col <= '0; r_best <= r_col_sums[0];
                        r_state <= S_CMIN;
                    end else begin
                        r_idx <= r_idx + 5'd1; r_rd_ok <= 1'b1;
                    end
                end
                S_CMIN: begin
                    if (r_idx >= r_nc) begin
                        r_col_plays[r_col] <= r_col_plays[r_col] + 1'b1;
                        r_idx <= '0; r_rd_ok <= 1'b0;
                        r_state <= S_RADD;
                    end else begin
                        if (w_cand < r_best) begin
                            r_best <= w_cand; r_col <= r_idx[COL_W-1:0];
                        end
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_RADD: begin
                    if (r_rd_ok)
                        r_row_sums[w_prev[ROW_W-1:0]] <= w_sum;
                    if (r_rd_ok && r_idx == r_nr) begin
                        // With a single row, row 0 is the sum written this cycle.
                        r_idx <= 5'd1; r_pick <= '0;
                        r_best <= (r_nr == 5'd1) ? w_sum : r_row_sums[0];
                        r_state <= S_RMAX;
                    end else begin
                        r_idx <= r_idx + 5'd1; r_rd_ok <= 1'b1;
                    end
                end
                S_RMAX: begin
                    if (r_idx >= r_nr) begin
                        r_round <= r_round + 1'b1;
                        r_rd_ok <= 1'b0;
                        if (r_round + 12'd1 == r_nrounds) begin
                            // r_best holds the greatest row sum; find least column.
                            r_num   <= DIV_W'(r_best);
                            r_idx   <= 5'd1;
                            r_best  <= r_col_sums[0];
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_CADD;
                        end
                    end else begin
                        if (w_cand > r_best) begin
                            r_best <= w_cand; r_pick <= r_idx[ROW_W-1:0];
                        end
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_FIN: begin
                    if (r_idx >= r_nc) begin
                        logic signed [DIV_W-1:0] v_tot;
                        v_tot = $signed(r_num) + DIV_W'(r_best);
                        r_neg <= v_tot[DIV_W-1];
                        r_num <= v_tot[DIV_W-1] ? DIV_W'(-v_tot) : DIV_W'(v_tot);
                        r_den <= {r_nrounds, 1'b0};
                        r_rem <= '0;
                        r_bit <= 5'(DIV_W - 1);
                        r_state <= S_DIV;
                    end else begin
                        if (w_cand < r_best) r_best <= w_cand;
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle into r_num.
                    if (!w_trial[DIV_W-1]) begin
                        r_rem <= w_trial;
                        r_num <= {r_num[DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DIV_W-2:0], r_num[DIV_W-1]};
                        r_num <= {r_num[DIV_W-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_emit == 6'd0) begin
                        if (r_neg)
                            r_value <= (r_num > DIV_W'(32768)) ? 16'sh8000 :
                                       16'(-$signed(r_num));
                        else
                            r_value <= (r_num > DIV_W'(32767)) ? 16'sh7fff : r_num[15:0];
                    end
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= n_odata;
                        r_emit   <= r_emit + 6'd1;
                        if (r_emit >= 6'(r_nr) + 6'(r_nc))
                            r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

FILE: sv/fpgs_checker.sv
// Port-level checker for the fictitious play solver, bound to the top level.
// Uses fpgs_pkg for result codes.
module fpgs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input fpgs_pkg::t_out o_data
);
    import fpgs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output request changed while stalled");
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last_result |-> o_stall)
        else $error("input taken in the middle of the result stream");
    a_last_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last_result |-> o_data.result_kind == KIND_VALUE)
        else $error("final result is not the game value");
    a_count_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.result_kind != KIND_VALUE |-> o_data.game_value == 16'sd0)
        else $error("count result carries a value");
endmodule

bind fictitious_play_game_solver fpgs_checker u_fpgs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for fictitious_play_game_solver: loads payoff matrices,
// predicts play counts and game value, and checks every result. Needs fpgs_pkg.
module testbench;
    import fpgs_pkg::*;

    typedef enum int { STEP_CFG, STEP_ONE, STEP_LOAD } step_e;

    typedef struct {
        step_e              op;
        logic [1:0]         reg_idx;
        logic [11:0]        reg_data;
        logic signed [15:0] entry;
        int                 n_entries;
        bit                 typed;
        logic [11:0]        typed_cnt;
        logic signed [15:0] typed_val;
    } step_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    // Predictor state.
    logic signed [15:0] payoff_mem [STORE_DEPTH];
    int                 load_ptr;
    int                 cfg_rows, cfg_cols, cfg_rounds;
    t_out               pending_results [$];

    int  errors;
    int  n_results;
    bit  hold_request;
    int  hold_left;
    int  rx_wait;

    step_t directed [] = '{
        '{STEP_CFG, REG_ROWS, 12'd1, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_CFG, REG_COLS, 12'd1, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_CFG, REG_ROUNDS, 12'd1, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_ONE, REG_ROWS, 12'd0, 16'sh7FFF, 1, 1, 12'd1, 16'sh7FFF},
        '{STEP_ONE, REG_ROWS, 12'd0, 16'sh8000, 1, 1, 12'd1, 16'sh8000},
        '{STEP_ONE, REG_ROWS, 12'd0, 16'sh0000, 1, 1, 12'd1, 16'sh0000},
        '{STEP_ONE, REG_ROWS, 12'd0, 16'sh5555, 1, 1, 12'd1, 16'sh5555},
        '{STEP_ONE, REG_ROWS, 12'd0, 16'shAAAA, 1, 1, 12'd1, 16'shAAAA},
        // A zero round count behaves as one round.
        '{STEP_CFG, REG_ROUNDS, 12'd0, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_ONE, REG_ROWS, 12'd0, 16'sh1234, 1, 1, 12'd1, 16'sh1234},
        '{STEP_CFG, REG_ROUNDS, 12'd4095, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_ONE, REG_ROWS, 12'd0, 16'shFFFF, 1, 1, 12'd4095, 16'shFFFF},
        // Oversized and zero sizes clamp to the legal range.
        '{STEP_CFG, REG_ROWS, 12'hFFF, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_CFG, REG_COLS, 12'd1, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_CFG, REG_ROUNDS, 12'd9, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_LOAD, REG_ROWS, 12'd0, 16'sd0, 16, 0, 12'd0, 16'sd0},
        '{STEP_CFG, REG_ROWS, 12'd0, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_CFG, REG_COLS, 12'd31, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_LOAD, REG_ROWS, 12'd0, 16'sd0, 16, 0, 12'd0, 16'sd0},
        // Short load: the tail of the row comes from the previous load.
        '{STEP_LOAD, REG_ROWS, 12'd0, 16'sd0, 5, 0, 12'd0, 16'sd0},
        '{STEP_CFG, REG_COLS, 12'd0, 16'sd0, 0, 0, 12'd0, 16'sd0},
        '{STEP_LOAD, REG_ROWS, 12'd0, 16'sd0, 1, 0, 12'd0, 16'sd0}
    };

    fictitious_play_game_solver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int clamp_size(int v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint cell_at(int r, int c, int nc);
        int addr;
        addr = r * nc + c;
        if (addr >= STORE_DEPTH) return 0;
        return longint'(payoff_mem[addr]);
    endfunction

    function automatic t_out make_result(logic [1:0] kind, int idx, int cnt,
                                         logic signed [15:0] val, bit last);
        t_out r;
        r.result_kind  = kind;
        r.result_index = 4'(idx);
        r.play_count   = 12'(cnt);
        r.game_value   = val;
        r.last_result  = last;
        return r;
    endfunction

    // Brown-Robinson play on the stored matrix; queues every result it emits.
    function automatic void play_out_game();
        longint row_sum [MAX_ROWS];
        longint col_sum [MAX_COLS];
        int     row_hits [MAX_ROWS];
        int     col_hits [MAX_COLS];
        int     nr, nc, nrounds, pick, col;
        longint best_row, least_col, val;
        nr      = clamp_size(cfg_rows, MAX_ROWS);
        nc      = clamp_size(cfg_cols, MAX_COLS);
        nrounds = (cfg_rounds < 1) ? 1 : cfg_rounds;
        for (int i = 0; i < MAX_ROWS; i++) begin
            row_sum[i] = 0;
            row_hits[i] = 0;
        end
        for (int j = 0; j < MAX_COLS; j++) begin
            col_sum[j] = 0;
            col_hits[j] = 0;
        end
        pick = 0;
        for (int n = 0; n < nrounds; n++) begin
            row_hits[pick]++;
            for (int j = 0; j < nc; j++) col_sum[j] += cell_at(pick, j, nc);
            col = 0;
            for (int j = 1; j < nc; j++) if (col_sum[j] < col_sum[col]) col = j;
            col_hits[col]++;
            for (int i = 0; i < nr; i++) row_sum[i] += cell_at(i, col, nc);
            pick = 0;
            for (int i = 1; i < nr; i++) if (row_sum[i] > row_sum[pick]) pick = i;
        end
        best_row = row_sum[0];
        for (int i = 1; i < nr; i++) if (row_sum[i] > best_row) best_row = row_sum[i];
        least_col = col_sum[0];
        for (int j = 1; j < nc; j++) if (col_sum[j] < least_col) least_col = col_sum[j];
        val = (best_row + least_col) / (2 * longint'(nrounds));
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        for (int i = 0; i < nr; i++)
            pending_results.push_back(make_result(KIND_ROW, i, row_hits[i], 16'sd0, 0));
        for (int j = 0; j < nc; j++)
            pending_results.push_back(make_result(KIND_COL, j, col_hits[j], 16'sd0, 0));
        pending_results.push_back(make_result(KIND_VALUE, 0, 0, 16'(val), 1));
    endfunction

    // Stores an accepted entry; on the last one, solves unless typed results apply.
    function automatic void take_entry(t_in d, bit predict);
        if (load_ptr >= STORE_DEPTH) load_ptr = 0;
        payoff_mem[load_ptr] = d.payoff_entry;
        load_ptr++;
        if (load_ptr >= STORE_DEPTH) load_ptr = 0;
        if (d.last_entry) begin
            load_ptr = 0;
            if (predict) play_out_game();
        end
    endfunction

    task automatic send_request(logic signed [15:0] entry, bit last, bit busy_sender,
                                bit predict);
        int gap;
        t_in d;
        gap = busy_sender ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        d.payoff_entry = entry;
        d.last_entry   = last;
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        take_entry(d, predict);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] data);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROWS:   cfg_rows   = int'(data[4:0]);
            REG_COLS:   cfg_cols   = int'(data[4:0]);
            REG_ROUNDS: cfg_rounds = int'(data);
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] pick_entry();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_matrix(int n, bit busy_sender);
        for (int k = 0; k < n; k++) send_request(pick_entry(), k == n - 1, busy_sender, 1);
    endtask

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", o_data);
            end else begin
                e = pending_results.pop_front();
                if (o_data.result_kind !== e.result_kind
                        || o_data.result_index !== e.result_index
                        || o_data.play_count !== e.play_count
                        || o_data.game_value !== e.game_value
                        || o_data.last_result !== e.last_result) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", e, o_data);
                end
            end
            // Every other block of 64 results goes out without receiver stalls.
            rx_wait = n_results[6] ? $urandom_range(0, 3) : 0;
        end
        // The long hold starts once results are on offer, so the block stays full.
        if (hold_request && o_valid && hold_left == 0) begin
            hold_request <= 1'b0;
            hold_left = 500;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        int rand_items, n, max_cells, pressure_left;
        bit busy_sender;
        errors = 0;
        n_results = 0;
        hold_left = 0;
        rx_wait = 0;
        hold_request = 1'b0;
        load_ptr = 0;
        cfg_rows = 16;
        cfg_cols = 16;
        cfg_rounds = 200;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_ROWS;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[s]) begin
            case (directed[s].op)
                STEP_CFG: write_reg(directed[s].reg_idx, directed[s].reg_data);
                STEP_ONE: begin
                    send_request(directed[s].entry, 1'b1, 1'b1, 1'b0);
                    pending_results.push_back(make_result(KIND_ROW, 0,
                        directed[s].typed_cnt, 16'sd0, 0));
                    pending_results.push_back(make_result(KIND_COL, 0,
                        directed[s].typed_cnt, 16'sd0, 0));
                    pending_results.push_back(make_result(KIND_VALUE, 0, 0,
                        directed[s].typed_val, 1));
                end
                default: load_matrix(directed[s].n_entries, 1'b1);
            endcase
        end

        // Entries 0 to 15 have been written, so loads up to 4 by 4 are safe.
        rand_items = 0;
        pressure_left = 4;
        while (rand_items < 100) begin
            if (pressure_left == 4 || (pressure_left == 0 && $urandom_range(0, 2) == 0)) begin
                max_cells = 4;
                write_reg(REG_ROWS, 12'($urandom_range(1, max_cells)));
                write_reg(REG_COLS, 12'($urandom_range(1, max_cells)));
                write_reg(REG_ROUNDS, ($urandom_range(0, 9) == 0) ?
                          12'($urandom_range(1, 400)) : 12'($urandom_range(1, 30)));
            end
            if (pressure_left == 3) hold_request <= 1'b1;
            if (pressure_left > 0) pressure_left--;
            n = clamp_size(cfg_rows, MAX_ROWS) * clamp_size(cfg_cols, MAX_COLS);
            if (n > 40) n = 40;
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            else n = n + $urandom_range(0, 1);
            busy_sender = ((rand_items / 40) % 2) == 0;
            load_matrix(n, busy_sender);
            rand_items += n;
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
